// File: rtl/key_value_pair_tokenizer_core_assert.svh
// Assertion macros used by the checker file.
`ifndef KEY_VALUE_PAIR_TOKENIZER_CORE_ASSERT_SVH
`define KEY_VALUE_PAIR_TOKENIZER_CORE_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define KVPT_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kvpt check failed");

// Next-cycle implication, masked during reset.
`define KVPT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kvpt check failed");

// Next-cycle implication that also holds across reset.
`define KVPT_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("kvpt check failed");

`endif

// File: rtl/kvpt_pkg.sv
`timescale 1ns / 1ps
package kvpt_pkg;

   localparam int MAX_LEN_DEFAULT = 4096;

   localparam int KEY_W     = 12;
   localparam int VAL_OFS_W = 12;
   localparam int VAL_LEN_W = 13;
   localparam int CONS_W    = 13;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_NUL     = 8'h00;

   typedef enum logic [2:0] {
      PH_SKIP_KEY,
      PH_KEY,
      PH_SKIP_VALUE,
      PH_VALUE,
      PH_DONE
   } kvpt_phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } kvpt_item_type;

   typedef struct packed {
      logic                 found;
      logic [KEY_W-1:0]     key_offset;
      logic [KEY_W-1:0]     key_length;
      logic [VAL_OFS_W-1:0] value_offset;
      logic [VAL_LEN_W-1:0] value_length;
      logic [CONS_W-1:0]    consumed;
      logic                 overflow;
   } kvpt_rsp_type;

endpackage

// File: rtl/kvpt_if.sv
`timescale 1ns / 1ps
interface kvpt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface kvpt_rsp_if import kvpt_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic                 found;
   logic [KEY_W-1:0]     key_offset;
   logic [KEY_W-1:0]     key_length;
   logic [VAL_OFS_W-1:0] value_offset;
   logic [VAL_LEN_W-1:0] value_length;
   logic [CONS_W-1:0]    consumed;
   logic                 overflow;

   modport source (
      output valid, output found, output key_offset, output key_length,
      output value_offset, output value_length, output consumed, output overflow,
      input ready
   );
   modport sink (
      input valid, input found, input key_offset, input key_length,
      input value_offset, input value_length, input consumed, input overflow,
      output ready
   );
endinterface

// File: rtl/kvpt_in_stage.sv
`timescale 1ns / 1ps
module kvpt_in_stage import kvpt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   kvpt_req_if.sink      req_bus,
   input  logic          out_free,
   output logic          item_valid,
   output kvpt_item_type item
);

   logic          valid_ff;
   logic          valid_in;
   kvpt_item_type item_ff;
   logic          advance;
   logic          take;

   // A final byte may only move on when the result register has room.
   assign advance = valid_ff && (!item_ff.last_byte || out_free);
   assign req_bus.ready = !valid_ff || advance;
   assign take = req_bus.valid && req_bus.ready;
   assign valid_in = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.data_byte <= req_bus.data_byte;
         item_ff.last_byte <= req_bus.last_byte;
      end
   end

   assign item_valid = advance;
   assign item = item_ff;

endmodule

// File: rtl/kvpt_parser.sv
`timescale 1ns / 1ps
module kvpt_parser import kvpt_pkg::*; #(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   input  kvpt_item_type item,
   output logic          rsp_load,
   output kvpt_rsp_type  rsp_data
);

   localparam int PosW = $clog2(MAX_LEN + 1);

   kvpt_phase_type       phase_ff, phase_nx, phase_in;
   logic [PosW-1:0]      position_ff, position_nx, position_in;
   logic [KEY_W-1:0]     key_begin_ff, key_begin_nx, key_begin_in;
   logic [KEY_W-1:0]     key_stop_ff, key_stop_nx, key_stop_in;
   logic                 key_stop_seen_ff, key_stop_seen_nx, key_stop_seen_in;
   logic [VAL_LEN_W-1:0] value_begin_ff, value_begin_nx, value_begin_in;
   logic [VAL_LEN_W-1:0] value_stop_ff, value_stop_nx, value_stop_in;
   logic                 too_long_ff, too_long_nx, too_long_in;

   logic                 at_limit;
   logic                 take;
   logic                 is_space;
   logic                 is_colon;
   logic                 is_vend;
   logic [KEY_W-1:0]     pos_key;
   logic [VAL_LEN_W-1:0] pos_val;
   logic [VAL_LEN_W-1:0] len_val;
   logic [VAL_LEN_W-1:0] vend;
   logic                 ends_item;

   assign at_limit = position_ff >= PosW'(MAX_LEN);
   assign take     = item_valid && !too_long_ff && !at_limit;
   assign is_space = item.data_byte == CHAR_SPACE;
   assign is_colon = item.data_byte == CHAR_COLON;
   assign is_vend  = is_space || item.data_byte == CHAR_NEWLINE ||
                     item.data_byte == CHAR_NUL;
   assign pos_key  = KEY_W'(position_ff);
   assign pos_val  = VAL_LEN_W'(position_ff);
   assign ends_item = item_valid && item.last_byte;

   // Phase after this byte.
   always_comb begin
      phase_nx = phase_ff;
      if (take) begin
         unique case (phase_ff)
            PH_SKIP_KEY: begin
               if (!is_space) phase_nx = PH_KEY;
            end
            PH_KEY: begin
               if (!is_space && is_colon) phase_nx = PH_SKIP_VALUE;
            end
            PH_SKIP_VALUE: begin
               if (!is_space) phase_nx = is_vend ? PH_DONE : PH_VALUE;
            end
            PH_VALUE: begin
               if (is_vend) phase_nx = PH_DONE;
            end
            default: phase_nx = phase_ff;
         endcase
      end
      phase_in = ends_item ? PH_SKIP_KEY : phase_nx;
   end

   // Positions and flags after this byte.
   always_comb begin
      position_nx      = position_ff;
      key_begin_nx     = key_begin_ff;
      key_stop_nx      = key_stop_ff;
      key_stop_seen_nx = key_stop_seen_ff;
      value_begin_nx   = value_begin_ff;
      value_stop_nx    = value_stop_ff;
      too_long_nx      = too_long_ff || (item_valid && at_limit);
      if (take) begin
         position_nx = position_ff + 1'b1;
         unique case (phase_ff)
            PH_SKIP_KEY: begin
               if (!is_space) begin
                  key_begin_nx     = pos_key;
                  key_stop_seen_nx = 1'b0;
               end
            end
            PH_KEY: begin
               if (is_space || is_colon) begin
                  if (!key_stop_seen_ff) begin
                     key_stop_nx      = pos_key;
                     key_stop_seen_nx = 1'b1;
                  end
               end else if (key_stop_seen_ff) begin
                  // restart the key after a space
                  key_begin_nx     = pos_key;
                  key_stop_seen_nx = 1'b0;
               end
            end
            PH_SKIP_VALUE: begin
               if (!is_space) begin
                  value_begin_nx = pos_val;
                  if (is_vend) value_stop_nx = pos_val;
               end
            end
            PH_VALUE: begin
               if (is_vend) value_stop_nx = pos_val;
            end
            default: begin
            end
         endcase
      end
      if (ends_item) begin
         position_in      = '0;
         key_begin_in     = '0;
         key_stop_in      = '0;
         key_stop_seen_in = 1'b0;
         value_begin_in   = '0;
         value_stop_in    = '0;
         too_long_in      = 1'b0;
      end else begin
         position_in      = position_nx;
         key_begin_in     = key_begin_nx;
         key_stop_in      = key_stop_nx;
         key_stop_seen_in = key_stop_seen_nx;
         value_begin_in   = value_begin_nx;
         value_stop_in    = value_stop_nx;
         too_long_in      = too_long_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_SKIP_KEY;
         position_ff      <= '0;
         key_begin_ff     <= '0;
         key_stop_ff      <= '0;
         key_stop_seen_ff <= 1'b0;
         value_begin_ff   <= '0;
         value_stop_ff    <= '0;
         too_long_ff      <= 1'b0;
      end else if (item_valid) begin
         phase_ff         <= phase_in;
         position_ff      <= position_in;
         key_begin_ff     <= key_begin_in;
         key_stop_ff      <= key_stop_in;
         key_stop_seen_ff <= key_stop_seen_in;
         value_begin_ff   <= value_begin_in;
         value_stop_ff    <= value_stop_in;
         too_long_ff      <= too_long_in;
      end
   end

   // Result from the state as it stands after the final byte.
   assign len_val = VAL_LEN_W'(position_nx);
   assign vend    = (phase_nx == PH_DONE) ? value_stop_nx : len_val;

   always_comb begin
      rsp_data = '0;
      if (too_long_nx) begin
         rsp_data.overflow = 1'b1;
      end else begin
         if (phase_nx == PH_VALUE || phase_nx == PH_DONE) begin
            rsp_data.found        = 1'b1;
            rsp_data.key_offset   = key_begin_nx;
            rsp_data.key_length   = key_stop_nx - key_begin_nx;
            rsp_data.value_offset = VAL_OFS_W'(value_begin_nx);
            rsp_data.value_length = vend - value_begin_nx;
         end
         rsp_data.consumed = CONS_W'(vend);
      end
   end

   assign rsp_load = ends_item;

endmodule

// File: rtl/kvpt_out_stage.sv
`timescale 1ns / 1ps
module kvpt_out_stage import kvpt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         rsp_load,
   input  kvpt_rsp_type rsp_data,
   output logic         out_free,
   kvpt_rsp_if.source   rsp_bus
);

   logic         valid_ff;
   logic         valid_in;
   kvpt_rsp_type data_ff;

   assign out_free = !valid_ff || rsp_bus.ready;
   assign valid_in = rsp_load || (valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         data_ff <= rsp_data;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.found        = data_ff.found;
   assign rsp_bus.key_offset   = data_ff.key_offset;
   assign rsp_bus.key_length   = data_ff.key_length;
   assign rsp_bus.value_offset = data_ff.value_offset;
   assign rsp_bus.value_length = data_ff.value_length;
   assign rsp_bus.consumed     = data_ff.consumed;
   assign rsp_bus.overflow     = data_ff.overflow;

endmodule

// File: rtl/key_value_pair_tokenizer_core.sv
// Key:value tokenizer, one buffer byte per request.
// Throughput: one byte per cycle unless a final byte waits for the result register.
// The final byte is registered in the input stage, the result in the output stage.
// A waiting result does not stall input bytes; only a further final byte waits for it.
// Reset (synchronous, active high) clears the parse state and both valid flags at once.
`timescale 1ns / 1ps
module key_value_pair_tokenizer_core import kvpt_pkg::*; #(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   kvpt_req_if.sink   req_bus,
   kvpt_rsp_if.source rsp_bus
);

   logic          out_free;
   logic          item_valid;
   kvpt_item_type item;
   logic          rsp_load;
   kvpt_rsp_type  rsp_data;

   kvpt_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .out_free   (out_free),
      .item_valid (item_valid),
      .item       (item)
   );

   kvpt_parser #(
      .MAX_LEN (MAX_LEN)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .rsp_load   (rsp_load),
      .rsp_data   (rsp_data)
   );

   kvpt_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .rsp_load (rsp_load),
      .rsp_data (rsp_data),
      .out_free (out_free),
      .rsp_bus  (rsp_bus)
   );

endmodule

// File: rtl/kvpt_checker.sv
`timescale 1ns / 1ps
`include "key_value_pair_tokenizer_core_assert.svh"
module kvpt_checker import kvpt_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_found,
   input logic [KEY_W-1:0]     rsp_key_offset,
   input logic [KEY_W-1:0]     rsp_key_length,
   input logic [VAL_OFS_W-1:0] rsp_value_offset,
   input logic [VAL_LEN_W-1:0] rsp_value_length,
   input logic [CONS_W-1:0]    rsp_consumed,
   input logic                 rsp_overflow
);

   // A stalled result keeps its flags.
   `KVPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found) && $stable(rsp_overflow) && $stable(rsp_consumed))

   `KVPT_ASSERT_ALWAYS_NEXT(a_reset_clears, clock, reset, !rsp_valid)

   // Overflow blanks every other field; found, consumed, key offset and value length are checked here.
   `KVPT_ASSERT_SAME(a_overflow_blank, clock, reset, rsp_valid && rsp_overflow, !rsp_found && rsp_consumed == '0 && rsp_key_offset == '0 && rsp_value_length == '0)

   // Without a pair, the key and value fields are zero.
   `KVPT_ASSERT_SAME(a_not_found_blank, clock, reset, rsp_valid && !rsp_found, rsp_key_offset == '0 && rsp_key_length == '0 && rsp_value_offset == '0 && rsp_value_length == '0)

endmodule

bind key_value_pair_tokenizer_core kvpt_checker u_kvpt_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_found        (rsp_bus.found),
   .rsp_key_offset   (rsp_bus.key_offset),
   .rsp_key_length   (rsp_bus.key_length),
   .rsp_value_offset (rsp_bus.value_offset),
   .rsp_value_length (rsp_bus.value_length),
   .rsp_consumed     (rsp_bus.consumed),
   .rsp_overflow     (rsp_bus.overflow)
);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import kvpt_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500000;

   typedef logic [7:0] text_q_type[$];

   // Tracks the parse of the current buffer and holds the results still owed by the block.
   class kvpt_scoreboard;
      kvpt_rsp_type   pending_rsp[$];
      kvpt_phase_type phase;
      int unsigned    position;
      int unsigned    key_begin;
      int unsigned    key_stop;
      int unsigned    value_begin;
      int unsigned    value_stop;
      bit             key_stop_seen;
      bit             too_long;
      int unsigned    errors;
      int unsigned    checked;
      int unsigned    found_cnt;
      int unsigned    overflow_cnt;

      function new();
         clear_parse();
      endfunction

      function void clear_parse();
         phase         = PH_SKIP_KEY;
         position      = 0;
         key_begin     = 0;
         key_stop      = 0;
         key_stop_seen = 1'b0;
         value_begin   = 0;
         value_stop    = 0;
         too_long      = 1'b0;
      endfunction

      function bit ends_value(logic [7:0] c);
         return c == CHAR_SPACE || c == CHAR_NEWLINE || c == CHAR_NUL;
      endfunction

      function void note_request(logic [7:0] c, logic is_last);
         kvpt_rsp_type want;
         int unsigned  vend;
         if (!too_long) begin
            if (position >= MAX_LEN_DEFAULT) begin
               too_long = 1'b1;
            end else begin
               case (phase)
                  PH_SKIP_KEY: begin
                     if (c != CHAR_SPACE) begin
                        key_begin     = position;
                        key_stop_seen = 1'b0;
                        phase         = PH_KEY;
                     end
                  end
                  PH_KEY: begin
                     if (c == CHAR_SPACE || c == CHAR_COLON) begin
                        if (!key_stop_seen) begin
                           key_stop      = position;
                           key_stop_seen = 1'b1;
                        end
                        if (c == CHAR_COLON) phase = PH_SKIP_VALUE;
                     end else if (key_stop_seen) begin
                        // a new word before any colon restarts the key
                        key_begin     = position;
                        key_stop_seen = 1'b0;
                     end
                  end
                  PH_SKIP_VALUE: begin
                     if (c != CHAR_SPACE) begin
                        value_begin = position;
                        if (ends_value(c)) begin
                           value_stop = position;
                           phase      = PH_DONE;
                        end else begin
                           phase = PH_VALUE;
                        end
                     end
                  end
                  PH_VALUE: begin
                     if (ends_value(c)) begin
                        value_stop = position;
                        phase      = PH_DONE;
                     end
                  end
                  default: ;
               endcase
               position++;
            end
         end
         if (!is_last) return;

         want = '0;
         if (too_long) begin
            want.overflow = 1'b1;
         end else begin
            if (phase == PH_VALUE || phase == PH_DONE) begin
               vend               = (phase == PH_DONE) ? value_stop : position;
               want.found         = 1'b1;
               want.key_offset    = KEY_W'(key_begin);
               want.key_length    = KEY_W'(key_stop - key_begin);
               want.value_offset  = VAL_OFS_W'(value_begin);
               want.value_length  = VAL_LEN_W'(vend - value_begin);
            end
            want.consumed = CONS_W'((phase == PH_DONE) ? value_stop : position);
         end
         pending_rsp.push_back(want);
         clear_parse();
      endfunction

      task report(string msg);
         $display("ERROR at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_field(string name, int unsigned got, int unsigned want);
         if (got != want)
            report($sformatf("response %0d field %s: got %0d, want %0d",
                             checked, name, got, want));
      endtask

      task check_response(kvpt_rsp_type got);
         kvpt_rsp_type want;
         if (pending_rsp.size() == 0) begin
            report("response arrived with no request outstanding");
            return;
         end
         want = pending_rsp.pop_front();
         checked++;
         if (want.found) found_cnt++;
         if (want.overflow) overflow_cnt++;
         check_field("found", 32'(got.found), 32'(want.found));
         check_field("key_offset", 32'(got.key_offset), 32'(want.key_offset));
         check_field("key_length", 32'(got.key_length), 32'(want.key_length));
         check_field("value_offset", 32'(got.value_offset), 32'(want.value_offset));
         check_field("value_length", 32'(got.value_length), 32'(want.value_length));
         check_field("consumed", 32'(got.consumed), 32'(want.consumed));
         check_field("overflow", 32'(got.overflow), 32'(want.overflow));
      endtask
   endclass

   logic           clock = 1'b0;
   logic           reset;
   bit             no_idle;
   bit             hold_go;
   int unsigned    cycle_count = 0;
   int unsigned    bytes_sent;
   int unsigned    buffers_sent;
   kvpt_rsp_type   rsp_seen;
   kvpt_scoreboard sb = new();

   kvpt_req_if req_bus();
   kvpt_rsp_if rsp_bus();

   key_value_pair_tokenizer_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, sb.pending_rsp.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Sample both channels on the same edge the block does.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.data_byte, req_bus.last_byte);
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_seen.found        = rsp_bus.found;
            rsp_seen.key_offset   = rsp_bus.key_offset;
            rsp_seen.key_length   = rsp_bus.key_length;
            rsp_seen.value_offset = rsp_bus.value_offset;
            rsp_seen.value_length = rsp_bus.value_length;
            rsp_seen.consumed     = rsp_bus.consumed;
            rsp_seen.overflow     = rsp_bus.overflow;
            sb.check_response(rsp_seen);
         end
      end
   end

   // Receiver: random back-pressure, plus one long hold-off when asked.
   initial begin
      int unsigned hold_left;
      bit          hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_taken) begin
            hold_left  = 400;
            hold_taken = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= no_idle || ($urandom_range(99) >= 14);
         end
      end
   end

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (c == CHAR_SPACE || c == CHAR_COLON || c == CHAR_NEWLINE || c == CHAR_NUL);
      return c;
   endfunction

   function automatic logic [7:0] any_char();
      logic [7:0] c;
      case ($urandom_range(9))
         0:       c = CHAR_SPACE;
         1:       c = CHAR_COLON;
         2:       c = CHAR_NEWLINE;
         3:       c = CHAR_NUL;
         default: c = 8'($urandom_range(255));
      endcase
      return c;
   endfunction

   function automatic text_q_type from_string(string s);
      text_q_type t;
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
      return t;
   endfunction

   // Well-formed pair with random words, spacing and terminator.
   function automatic text_q_type build_pair();
      text_q_type  t;
      int unsigned term;
      repeat ($urandom_range(3)) t.push_back(CHAR_SPACE);
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(1, 3)) t.push_back(plain_char());
         repeat ($urandom_range(1, 2)) t.push_back(CHAR_SPACE);
      end
      repeat ($urandom_range(1, 5)) t.push_back(plain_char());
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) t.push_back(CHAR_SPACE);
      t.push_back(CHAR_COLON);
      repeat ($urandom_range(3)) t.push_back(CHAR_SPACE);
      repeat ($urandom_range(6)) t.push_back(plain_char());
      term = $urandom_range(3);
      case (term)
         1: t.push_back(CHAR_SPACE);
         2: t.push_back(CHAR_NEWLINE);
         3: t.push_back(CHAR_NUL);
         default: ;
      endcase
      if (term != 0) repeat ($urandom_range(4)) t.push_back(any_char());
      return t;
   endfunction

   function automatic text_q_type random_buffer();
      text_q_type  t;
      int unsigned pick;
      int unsigned keep;
      pick = $urandom_range(99);
      if (pick < 70) begin
         t = build_pair();
      end else if (pick < 85) begin
         // cut a pair short
         t    = build_pair();
         keep = $urandom_range(1, t.size());
         while (t.size() > keep) void'(t.pop_back());
      end else begin
         repeat ($urandom_range(1, 10)) t.push_back(any_char());
      end
      return t;
   endfunction

   task automatic drive_byte(input logic [7:0] c, input logic is_last);
      if (!no_idle && $urandom_range(99) < 12) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= c;
      req_bus.last_byte <= is_last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      bytes_sent++;
   endtask

   task automatic send_buffer(input text_q_type t);
      for (int i = 0; i < t.size(); i++) drive_byte(t[i], i == t.size() - 1);
      buffers_sent++;
   endtask

   initial begin
      text_q_type  t;
      int unsigned small_sent;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= '0;
      req_bus.last_byte <= 1'b0;
      reset             <= 1'b1;
      no_idle            = 1'b0;
      hold_go            = 1'b0;
      small_sent         = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // leading space, key restart, value opening on a newline
      send_buffer(from_string(" a b:\n"));
      // key that starts with a colon, bytes after the terminator
      send_buffer(from_string("::x yz"));
      // nothing after the colon
      t = {8'hFF, CHAR_COLON};
      send_buffer(t);
      // no colon at all
      send_buffer(from_string("z"));
      // value opening on NUL after spaces
      t = from_string("k:  ");
      t.push_back(CHAR_NUL);
      send_buffer(t);
      // value running to the end of the buffer
      send_buffer(from_string("q:v"));

      while (small_sent < 300) begin
         t = random_buffer();
         send_buffer(t);
         small_sent += t.size();
      end

      no_idle = 1'b1;
      while (small_sent < 500) begin
         t = random_buffer();
         send_buffer(t);
         small_sent += t.size();
      end
      no_idle = 1'b0;

      // hold the result side while short buffers keep coming
      hold_go = 1'b1;
      repeat (20) begin
         t = build_pair();
         send_buffer(t);
         small_sent += t.size();
      end

      while (small_sent < 800) begin
         t = random_buffer();
         send_buffer(t);
         small_sent += t.size();
      end
      req_bus.valid <= 1'b0;

      // let the final request reach the scoreboard before draining
      @(posedge clock);
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("sent %0d buffers (%0d bytes) with random spacing, key restarts and a long hold-off",
               buffers_sent, bytes_sent);
      $display("checked %0d results: %0d with a pair, %0d overflowed, %0d mismatches",
               sb.checked, sb.found_cnt, sb.overflow_cnt, sb.errors);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/kvpt_pkg.sv
rtl/kvpt_if.sv
rtl/kvpt_in_stage.sv
rtl/kvpt_parser.sv
rtl/kvpt_out_stage.sv
rtl/key_value_pair_tokenizer_core.sv
rtl/kvpt_checker.sv
verif/tb_top.sv
